>>> rtl/core/sjbt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjbt_pkg
// Shared types and constants for the slotted jittered beacon timer.
// ----------------------------------------------------------------------------
package sjbt_pkg;

    localparam int MS_W      = 32;
    localparam int SEQ_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int DIVR_W    = 11;
    localparam int STEP_W    = 6;

    localparam logic [MS_W-1:0] LCG_MUL    = 32'd1103515245;
    localparam logic [MS_W-1:0] LCG_ADD    = 32'd12345;
    localparam logic [9:0]      MS_PER_SEC = 10'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_TAG_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_RATE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JITTER_MAX = 2'd3;

    typedef logic [MS_W-1:0]  t_ms;
    typedef logic [SEQ_W-1:0] t_seq;

    typedef struct packed {
        logic              start;
        logic [MS_W-1:0]   dividend;
        logic [DIVR_W-1:0] divisor;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [MS_W-1:0]   quot;
        logic [DIVR_W-1:0] rem;
    } t_div_rsp;

endpackage
`default_nettype wire

>>> rtl/core/sjbt_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjbt_ifs
// Valid/ready channels: time samples in, blink results out.
// ----------------------------------------------------------------------------
interface sjbt_in_if import sjbt_pkg::*; ();
    logic valid;
    logic ready;
    t_ms  now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

interface sjbt_out_if import sjbt_pkg::*; ();
    logic valid;
    logic ready;
    logic blink_fire;
    t_seq blink_seq;

    modport source (output valid, output blink_fire, output blink_seq, input ready);
    modport sink   (input valid, input blink_fire, input blink_seq, output ready);
endinterface
`default_nettype wire

>>> rtl/core/slotted_jittered_beacon_timer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slotted_jittered_beacon_timer
// Blink scheduler: slot offset per tag plus LCG jitter on the blink interval.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample carries the current millisecond time; each transaction yields
//   exactly one transaction on o_blink (blink_fire, blink_seq).
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must do so only while the block is idle, which the block itself
//   does not enforce. Indexes: tag id, slot count, blink rate, jitter max.
//   A sample takes four passes through one shared bit-serial divider (10 + 16
//   + 10 + 32 steps: interval, tag slot, slot width, jitter modulo) plus
//   sequencing, so a new sample is taken only after the last one has left
//   its compare step. i_sample.ready is high only while the sequencer is idle.
//   The result sits in an output register; if o_blink is stalled, the next
//   sample may still be accepted and the block waits at its compare step
//   until the register frees up.
//   Reset (synchronous, active low) clears sequence count and last blink time
//   and loads register defaults: tag 0, one slot, 10 Hz, no jitter.
// ----------------------------------------------------------------------------
module slotted_jittered_beacon_timer import sjbt_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    sjbt_in_if.sink                   i_sample,
    sjbt_out_if.source                o_blink
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PER  = 3'd1;
    localparam logic [2:0] S_TAG  = 3'd2;
    localparam logic [2:0] S_SLT  = 3'd3;
    localparam logic [2:0] S_JIT  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;

    logic [2:0]  r_state, n_state;

    logic [15:0] r_tag_id;
    logic [7:0]  r_slot_count;
    logic [9:0]  r_rate;
    logic [9:0]  r_jmax;

    t_seq        r_seq;
    t_ms         r_last;
    t_ms         r_now;
    t_ms         r_seed;
    logic [9:0]  r_period;
    logic [7:0]  r_tag_mod;
    t_ms         r_base;
    t_ms         r_due;

    logic        r_out_valid;
    logic        r_out_fire;
    t_seq        r_out_seq;

    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic        in_acc;
    logic        out_load;
    logic        fire;
    logic [9:0]  rate_eff;
    logic [7:0]  slots_eff;
    logic [11:0] jit_diff;
    logic [17:0] slot_prod;
    t_ms         offset;

    assign rate_eff  = (r_rate == '0) ? 10'd1 : r_rate;
    assign slots_eff = (r_slot_count == '0) ? 8'd1 : r_slot_count;
    assign in_acc    = i_sample.valid && i_sample.ready;
    assign fire      = (r_now >= r_due);
    assign out_load  = (r_state == S_CMP) && (!r_out_valid || o_blink.ready);
    assign jit_diff  = {1'b0, div_rsp.rem} - {2'b00, r_jmax};
    assign slot_prod = r_tag_mod * div_rsp.quot[9:0];
    assign offset    = {{(MS_W-18){1'b0}}, slot_prod};

    sjbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // divider sequencing
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        div_req.steps    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {MS_PER_SEC, 22'd0};
                    div_req.divisor  = {1'b0, rate_eff};
                    div_req.steps    = STEP_W'(10);
                    n_state          = S_PER;
                end
            end
            S_PER: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {r_tag_id, 16'd0};
                    div_req.divisor  = {3'd0, slots_eff};
                    div_req.steps    = STEP_W'(16);
                    n_state          = S_TAG;
                end
            end
            S_TAG: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {r_period, 22'd0};
                    div_req.divisor  = {3'd0, slots_eff};
                    div_req.steps    = STEP_W'(10);
                    n_state          = S_SLT;
                end
            end
            S_SLT: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_seed;
                    div_req.divisor  = {r_jmax, 1'b1};
                    div_req.steps    = STEP_W'(32);
                    n_state          = S_JIT;
                end
            end
            S_JIT: begin
                if (div_rsp.done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tag_id     <= '0;
            r_slot_count <= 8'd1;
            r_rate       <= 10'd10;
            r_jmax       <= '0;
            r_seq        <= '0;
            r_last       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TAG_ID:     r_tag_id     <= i_cfg_data;
                    CFG_SLOT_COUNT: r_slot_count <= i_cfg_data[7:0];
                    CFG_BLINK_RATE: r_rate       <= i_cfg_data[9:0];
                    CFG_JITTER_MAX: r_jmax       <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (out_load && fire) begin
                r_seq  <= r_seq + 1'b1;
                r_last <= r_now;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_blink.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now  <= i_sample.now_ms;
            r_seed <= MS_W'({16'd0, r_seq} * LCG_MUL + LCG_ADD);
        end
        if (r_state == S_PER && div_rsp.done) begin
            r_period <= div_rsp.quot[9:0];
        end
        if (r_state == S_TAG && div_rsp.done) begin
            r_tag_mod <= div_rsp.rem[7:0];
        end
        if (r_state == S_SLT && div_rsp.done) begin
            r_base <= r_last + MS_W'(r_period) + offset;
        end
        if (r_state == S_JIT && div_rsp.done) begin
            r_due <= r_base + {{(MS_W-12){jit_diff[11]}}, jit_diff};
        end
        if (out_load) begin
            r_out_fire <= fire;
            r_out_seq  <= fire ? r_seq : '0;
        end
    end

    assign i_sample.ready     = (r_state == S_IDLE);
    assign o_blink.valid      = r_out_valid;
    assign o_blink.blink_fire = r_out_fire;
    assign o_blink.blink_seq  = r_out_seq;

endmodule
`default_nettype wire

>>> rtl/core/sjbt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjbt_div
// Shared restoring divider, one quotient bit per cycle. The dividend comes in
// left-aligned; after the given number of steps the low bits hold the quotient.
// ----------------------------------------------------------------------------
module sjbt_div import sjbt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic [STEP_W-1:0] r_cnt;
    logic              r_done;
    logic [MS_W-1:0]   r_q;
    logic [DIVR_W-1:0] r_rem;
    logic [DIVR_W-1:0] r_div;

    logic [DIVR_W:0]   rem_sh;
    logic [DIVR_W:0]   diff;
    logic              ge;

    assign rem_sh = {r_rem, r_q[MS_W-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign ge     = (rem_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= i_req.steps;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[MS_W-2:0], ge};
            r_rem <= ge ? diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

>>> rtl/core/sjbt_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sjbt_chk
// Port-level checks for the beacon timer, bound to the top level.
// ----------------------------------------------------------------------------
module sjbt_chk import sjbt_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_fire,
    input wire t_seq i_out_seq
);

    // reset leaves the block idle with nothing to deliver
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("not idle after reset");

    // one sample in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken while busy");

    // quiet samples report sequence zero
    a_quiet_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_fire |-> i_out_seq == '0)
        else $error("sequence set on quiet result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped under stall");

endmodule

bind slotted_jittered_beacon_timer sjbt_chk u_sjbt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_blink.valid),
    .i_out_ready (o_blink.ready),
    .i_out_fire  (o_blink.blink_fire),
    .i_out_seq   (o_blink.blink_seq)
);
`default_nettype wire
